### rtl/core/kmst_pkg.sv
// kmst_pkg: shared types, codes and default sizes of the keyed message snapshot table
// depends on nothing; used by kmst_ctrl and the top level
`default_nettype none

package kmst_pkg;

    localparam int RECORDS_DEF = 32;
    localparam int MAX_LEN_DEF = 1785;

    localparam int SLOT_IN_W = 5;
    localparam int LEN_W     = 11;
    localparam int TS_W      = 32;
    localparam int PER_W     = 16;
    localparam int SA_W      = 8;
    localparam int PGN_W     = 18;

    localparam logic [1:0] OP_UPDATE  = 2'd0;
    localparam logic [1:0] OP_COLLECT = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    localparam logic [2:0] KIND_STORED = 3'd0;
    localparam logic [2:0] KIND_REJECT = 3'd1;
    localparam logic [2:0] KIND_LIVE   = 3'd2;
    localparam logic [2:0] KIND_BYTE   = 3'd3;
    localparam logic [2:0] KIND_END    = 3'd4;

    typedef struct packed {
        logic [1:0]           op;
        logic [SA_W-1:0]      source_addr;
        logic [PGN_W-1:0]     pgn;
        logic [TS_W-1:0]      now_ms;
        logic [LEN_W-1:0]     msg_len;
        logic [7:0]           data_byte;
        logic [SLOT_IN_W-1:0] slot;
        logic [LEN_W-1:0]     byte_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0]           kind;
        logic [SLOT_IN_W-1:0] rec_slot;
        logic [SA_W-1:0]      rec_source_addr;
        logic [PGN_W-1:0]     rec_pgn;
        logic [PER_W-1:0]     period_ms;
        logic [TS_W-1:0]      last_ts_ms;
        logic [LEN_W-1:0]     rec_len;
        logic [7:0]           read_byte;
        logic                 last;
    } out_item_t;

    // one record's metadata, one memory word
    typedef struct packed {
        logic [SA_W-1:0]  src;
        logic [PGN_W-1:0] grp;
        logic [TS_W-1:0]  stamp;
        logic [PER_W-1:0] period;
        logic [LEN_W-1:0] len;
    } meta_t;

endpackage

`default_nettype wire

### rtl/core/kmst_ram.sv
// kmst_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
`default_nettype none

module kmst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/core/kmst_ctrl.sv
// kmst_ctrl: sequencer of the snapshot table: key scan, replacement, payload
// streaming, collect walk, byte read and the result register; uses kmst_pkg
`default_nettype none

module kmst_ctrl #(
    parameter int RECORDS = kmst_pkg::RECORDS_DEF,
    parameter int MAX_LEN = kmst_pkg::MAX_LEN_DEF,
    localparam int SLOT_W = $clog2(RECORDS),
    localparam int ADDR_W = $clog2(RECORDS * MAX_LEN)
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic [kmst_pkg::TS_W-1:0] ttl_ms,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire kmst_pkg::in_item_t       s_item,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output kmst_pkg::out_item_t           m_item,
    output logic                          meta_we,
    output logic [SLOT_W-1:0]             meta_waddr,
    output kmst_pkg::meta_t               meta_wdata,
    output logic [SLOT_W-1:0]             meta_raddr,
    input  wire kmst_pkg::meta_t          meta_rdata,
    output logic                          pay_we,
    output logic [ADDR_W-1:0]             pay_waddr,
    output logic [7:0]                    pay_wdata,
    output logic [ADDR_W-1:0]             pay_raddr,
    input  wire logic [7:0]               pay_rdata
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_REJ   = 4'd1;
    localparam logic [3:0] ST_SCAN  = 4'd2;
    localparam logic [3:0] ST_SLAST = 4'd3;
    localparam logic [3:0] ST_PICK  = 4'd4;
    localparam logic [3:0] ST_WR    = 4'd5;
    localparam logic [3:0] ST_UPD   = 4'd6;
    localparam logic [3:0] ST_CRD   = 4'd7;
    localparam logic [3:0] ST_CCHK  = 4'd8;
    localparam logic [3:0] ST_CEND  = 4'd9;
    localparam logic [3:0] ST_RD    = 4'd10;
    localparam logic [3:0] ST_ROUT  = 4'd11;
    localparam logic [3:0] ST_RBAD  = 4'd12;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RECORDS - 1);

    logic [3:0]                     state_reg, state_next;
    kmst_pkg::in_item_t             in_reg, in_next;
    logic [SLOT_W-1:0]              idx_reg, idx_next;
    logic                           chk_vld_reg, chk_vld_next;
    logic [SLOT_W-1:0]              chk_idx_reg, chk_idx_next;
    logic                           hit_reg, hit_next;
    logic [SLOT_W-1:0]              hit_slot_reg, hit_slot_next;
    logic [kmst_pkg::TS_W-1:0]      hit_stamp_reg, hit_stamp_next;
    logic                           free_reg, free_next;
    logic [SLOT_W-1:0]              free_slot_reg, free_slot_next;
    logic                           old_reg, old_next;
    logic [SLOT_W-1:0]              old_slot_reg, old_slot_next;
    logic [kmst_pkg::TS_W-1:0]      old_stamp_reg, old_stamp_next;
    logic [SLOT_W-1:0]              cur_slot_reg, cur_slot_next;
    logic [kmst_pkg::PER_W-1:0]     cur_per_reg, cur_per_next;
    logic [kmst_pkg::TS_W-1:0]      cur_stamp_reg, cur_stamp_next;
    logic [ADDR_W-1:0]              base_reg, base_next;
    logic                           active_reg, active_next;
    logic [kmst_pkg::LEN_W-1:0]     beat_reg, beat_next;
    logic [RECORDS-1:0]             valid_reg, valid_next;
    logic                           out_valid_reg, out_valid_next;
    kmst_pkg::out_item_t            out_reg, out_next;

    logic                           out_free;
    logic                           emit;
    kmst_pkg::out_item_t            emit_item;
    logic                           accept;
    logic                           len_bad;
    logic                           chk_v;
    logic                           rd_slot_ok;
    logic [SLOT_W-1:0]              rd_slot;
    logic [ADDR_W-1:0]              cur_base;
    logic [kmst_pkg::LEN_W:0]       beat_inc;
    logic [kmst_pkg::TS_W-1:0]      age;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;
    assign m_item   = out_reg;

    assign len_bad    = (in_reg.msg_len == '0) || (32'(in_reg.msg_len) > 32'(MAX_LEN));
    assign chk_v      = valid_reg[chk_idx_reg];
    assign rd_slot    = SLOT_W'(in_reg.slot);
    assign rd_slot_ok = (32'(in_reg.slot) < 32'(RECORDS)) && valid_reg[rd_slot];
    assign cur_base   = ADDR_W'(cur_slot_reg) * ADDR_W'(MAX_LEN);
    assign beat_inc   = {1'b0, beat_reg} + 1'b1;
    assign age        = in_reg.now_ms - meta_rdata.stamp;

    always_comb begin
        meta_raddr = idx_reg;
        if (state_reg == ST_RD || state_reg == ST_ROUT) begin
            meta_raddr = rd_slot;
        end
    end

    assign pay_raddr = ADDR_W'(rd_slot) * ADDR_W'(MAX_LEN) + ADDR_W'(in_reg.byte_index);

    assign meta_we    = (state_reg == ST_WR);
    assign meta_waddr = cur_slot_reg;
    assign meta_wdata = '{src: in_reg.source_addr, grp: in_reg.pgn, stamp: in_reg.now_ms,
                          period: cur_per_reg, len: in_reg.msg_len};

    always_comb begin
        pay_we    = 1'b0;
        pay_waddr = base_reg + ADDR_W'(beat_reg);
        pay_wdata = s_item.data_byte;
        if (state_reg == ST_WR) begin
            pay_we    = 1'b1;
            pay_waddr = cur_base;
            pay_wdata = in_reg.data_byte;
        end else if (accept && s_item.op == kmst_pkg::OP_UPDATE && active_reg) begin
            pay_we = 1'b1;
        end
    end

    always_comb begin
        state_next     = state_reg;
        in_next        = in_reg;
        idx_next       = idx_reg;
        chk_vld_next   = 1'b0;
        chk_idx_next   = chk_idx_reg;
        hit_next       = hit_reg;
        hit_slot_next  = hit_slot_reg;
        hit_stamp_next = hit_stamp_reg;
        free_next      = free_reg;
        free_slot_next = free_slot_reg;
        old_next       = old_reg;
        old_slot_next  = old_slot_reg;
        old_stamp_next = old_stamp_reg;
        cur_slot_next  = cur_slot_reg;
        cur_per_next   = cur_per_reg;
        cur_stamp_next = cur_stamp_reg;
        base_next      = base_reg;
        active_next    = active_reg;
        beat_next      = beat_reg;
        valid_next     = valid_reg;
        emit           = 1'b0;
        emit_item      = '0;

        // scan evaluation of the entry read in the previous cycle
        if (chk_vld_reg) begin
            if (chk_v && meta_rdata.src == in_reg.source_addr
                    && meta_rdata.grp == in_reg.pgn && !hit_reg) begin
                hit_next       = 1'b1;
                hit_slot_next  = chk_idx_reg;
                hit_stamp_next = meta_rdata.stamp;
            end
            if (!chk_v && !free_reg) begin
                free_next      = 1'b1;
                free_slot_next = chk_idx_reg;
            end
            if (chk_v && (!old_reg || meta_rdata.stamp < old_stamp_reg)) begin
                old_next       = 1'b1;
                old_slot_next  = chk_idx_reg;
                old_stamp_next = meta_rdata.stamp;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    in_next  = s_item;
                    idx_next = '0;
                    case (s_item.op)
                        kmst_pkg::OP_UPDATE: begin
                            if (active_reg) begin
                                beat_next = beat_inc[kmst_pkg::LEN_W-1:0];
                                if (beat_inc >= {1'b0, in_reg.msg_len}) begin
                                    // keep the first beat's key and length
                                    in_next     = in_reg;
                                    active_next = 1'b0;
                                    beat_next   = '0;
                                    state_next  = ST_UPD;
                                end else begin
                                    in_next = in_reg;
                                end
                            end else begin
                                hit_next   = 1'b0;
                                free_next  = 1'b0;
                                old_next   = 1'b0;
                                state_next = ST_SCAN;
                            end
                        end
                        kmst_pkg::OP_COLLECT: state_next = ST_CRD;
                        kmst_pkg::OP_READ:    state_next = ST_RD;
                        default:              state_next = ST_IDLE;
                    endcase
                    // a collect or read mid-message must not lose the message's latched fields
                    if (active_reg && s_item.op != kmst_pkg::OP_UPDATE) begin
                        in_next.source_addr = in_reg.source_addr;
                        in_next.pgn         = in_reg.pgn;
                        in_next.msg_len     = in_reg.msg_len;
                        in_next.data_byte   = in_reg.data_byte;
                    end
                end
            end
            ST_SCAN: begin
                if (len_bad) begin
                    state_next = ST_REJ;
                end else begin
                    chk_vld_next = 1'b1;
                    chk_idx_next = idx_reg;
                    if (idx_reg == LAST_SLOT) begin
                        state_next = ST_SLAST;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_SLAST: state_next = ST_PICK;
            ST_PICK: begin
                cur_per_next   = '0;
                cur_stamp_next = in_reg.now_ms;
                if (hit_reg) begin
                    cur_slot_next = hit_slot_reg;
                    if (hit_stamp_reg != '0) begin
                        cur_per_next = kmst_pkg::PER_W'(in_reg.now_ms - hit_stamp_reg);
                    end
                end else if (free_reg) begin
                    cur_slot_next = free_slot_reg;
                end else begin
                    cur_slot_next = old_slot_reg;
                end
                state_next = ST_WR;
            end
            ST_WR: begin
                valid_next[cur_slot_reg] = 1'b1;
                base_next = cur_base;
                if (in_reg.msg_len == kmst_pkg::LEN_W'(1)) begin
                    active_next = 1'b0;
                    beat_next   = '0;
                    state_next  = ST_UPD;
                end else begin
                    active_next = 1'b1;
                    beat_next   = kmst_pkg::LEN_W'(1);
                    state_next  = ST_IDLE;
                end
            end
            ST_UPD: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_item = '{kind: kmst_pkg::KIND_STORED,
                                  rec_slot: kmst_pkg::SLOT_IN_W'(cur_slot_reg),
                                  rec_source_addr: in_reg.source_addr, rec_pgn: in_reg.pgn,
                                  period_ms: cur_per_reg, last_ts_ms: cur_stamp_reg,
                                  rec_len: in_reg.msg_len, read_byte: '0, last: 1'b1};
                    state_next = ST_IDLE;
                end
            end
            ST_REJ: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_item = '{kind: kmst_pkg::KIND_REJECT, rec_slot: '0,
                                  rec_source_addr: in_reg.source_addr, rec_pgn: in_reg.pgn,
                                  period_ms: '0, last_ts_ms: '0, rec_len: '0,
                                  read_byte: '0, last: 1'b1};
                    state_next = ST_IDLE;
                end
            end
            ST_CRD: state_next = ST_CCHK;
            ST_CCHK: begin
                if (valid_reg[idx_reg] && age <= ttl_ms) begin
                    if (out_free) begin
                        emit      = 1'b1;
                        emit_item = '{kind: kmst_pkg::KIND_LIVE,
                                      rec_slot: kmst_pkg::SLOT_IN_W'(idx_reg),
                                      rec_source_addr: meta_rdata.src, rec_pgn: meta_rdata.grp,
                                      period_ms: meta_rdata.period,
                                      last_ts_ms: meta_rdata.stamp,
                                      rec_len: meta_rdata.len, read_byte: '0, last: 1'b0};
                    end
                end
                if (out_free || !(valid_reg[idx_reg] && age <= ttl_ms)) begin
                    if (idx_reg == LAST_SLOT) begin
                        state_next = ST_CEND;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_CRD;
                    end
                end
            end
            ST_CEND: begin
                if (out_free) begin
                    emit           = 1'b1;
                    emit_item      = '0;
                    emit_item.kind = kmst_pkg::KIND_END;
                    emit_item.last = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_RD: state_next = rd_slot_ok ? ST_ROUT : ST_RBAD;
            ST_ROUT: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_item = '{kind: kmst_pkg::KIND_BYTE, rec_slot: in_reg.slot,
                                  rec_source_addr: meta_rdata.src, rec_pgn: meta_rdata.grp,
                                  period_ms: meta_rdata.period, last_ts_ms: meta_rdata.stamp,
                                  rec_len: meta_rdata.len,
                                  read_byte: (in_reg.byte_index < meta_rdata.len)
                                             ? pay_rdata : 8'd0,
                                  last: 1'b0};
                    state_next = ST_IDLE;
                end
            end
            ST_RBAD: begin
                if (out_free) begin
                    emit               = 1'b1;
                    emit_item          = '0;
                    emit_item.kind     = kmst_pkg::KIND_BYTE;
                    emit_item.rec_slot = in_reg.slot;
                    state_next         = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            out_next       = emit_item;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            chk_vld_reg   <= 1'b0;
            active_reg    <= 1'b0;
            beat_reg      <= '0;
            cur_slot_reg  <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            chk_vld_reg   <= chk_vld_next;
            active_reg    <= active_next;
            beat_reg      <= beat_next;
            cur_slot_reg  <= cur_slot_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg        <= in_next;
        idx_reg       <= idx_next;
        chk_idx_reg   <= chk_idx_next;
        hit_reg       <= hit_next;
        hit_slot_reg  <= hit_slot_next;
        hit_stamp_reg <= hit_stamp_next;
        free_reg      <= free_next;
        free_slot_reg <= free_slot_next;
        old_reg       <= old_next;
        old_slot_reg  <= old_slot_next;
        old_stamp_reg <= old_stamp_next;
        cur_per_reg   <= cur_per_next;
        cur_stamp_reg <= cur_stamp_next;
        base_reg      <= base_next;
        out_reg       <= out_next;
    end

endmodule

`default_nettype wire

### rtl/core/keyed_message_snapshot_table.sv
// The table takes one transaction at a time. A first update beat scans the record
// metadata memory one slot a cycle; continuing beats write payload bytes, and the
// beat that completes a message emits the stored result. A collect walks the metadata
// memory slot by slot and waits out any output stall, a read returns one payload byte,
// and a bad length is rejected. Results leave through an output register, so the next
// transaction is taken while a result waits.
// keyed_message_snapshot_table: top level; holds the ttl register, the metadata and
// payload memories and the port packing; uses kmst_pkg, kmst_ram and kmst_ctrl
`default_nettype none

module keyed_message_snapshot_table #(
    parameter int RECORDS = kmst_pkg::RECORDS_DEF,
    parameter int MAX_LEN = kmst_pkg::MAX_LEN_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [31:0]  cfg_data,      // ttl_ms
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,       // source_addr, pgn, now_ms, msg_len, data_byte,
                                             // slot, byte_index
    input  wire logic [1:0]   s_tuser,       // op
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0]      m_tdata,       // rec_slot, rec_source_addr, rec_pgn, period_ms,
                                             // last_ts_ms, rec_len, read_byte
    output logic [2:0]        m_tuser,       // kind
    output logic              m_tlast        // last
);

    localparam int SLOT_W = $clog2(RECORDS);
    localparam int ADDR_W = $clog2(RECORDS * MAX_LEN);

    logic [31:0]          ttl_reg;
    kmst_pkg::in_item_t   s_item;
    kmst_pkg::out_item_t  m_item;
    logic                 meta_we;
    logic [SLOT_W-1:0]    meta_waddr, meta_raddr;
    kmst_pkg::meta_t      meta_wdata, meta_rdata;
    logic                 pay_we;
    logic [ADDR_W-1:0]    pay_waddr, pay_raddr;
    logic [7:0]           pay_wdata, pay_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ttl_reg <= 32'd1000;
        end else if (cfg_valid) begin
            ttl_reg <= cfg_data;
        end
    end

    always_comb begin
        s_item.op          = s_tuser;
        s_item.source_addr = s_tdata[7:0];
        s_item.pgn         = s_tdata[25:8];
        s_item.now_ms      = s_tdata[57:26];
        s_item.msg_len     = s_tdata[68:58];
        s_item.data_byte   = s_tdata[76:69];
        s_item.slot        = s_tdata[81:77];
        s_item.byte_index  = s_tdata[92:82];
    end

    assign m_tdata = {6'd0, m_item.read_byte, m_item.rec_len, m_item.last_ts_ms,
                      m_item.period_ms, m_item.rec_pgn, m_item.rec_source_addr,
                      m_item.rec_slot};
    assign m_tuser = m_item.kind;
    assign m_tlast = m_item.last;

    kmst_ctrl #(
        .RECORDS (RECORDS),
        .MAX_LEN (MAX_LEN)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ttl_ms     (ttl_reg),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_item     (m_item),
        .meta_we    (meta_we),
        .meta_waddr (meta_waddr),
        .meta_wdata (meta_wdata),
        .meta_raddr (meta_raddr),
        .meta_rdata (meta_rdata),
        .pay_we     (pay_we),
        .pay_waddr  (pay_waddr),
        .pay_wdata  (pay_wdata),
        .pay_raddr  (pay_raddr),
        .pay_rdata  (pay_rdata)
    );

    kmst_ram #(
        .WIDTH ($bits(kmst_pkg::meta_t)),
        .DEPTH (RECORDS)
    ) u_meta_ram (
        .aclk  (aclk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    kmst_ram #(
        .WIDTH (8),
        .DEPTH (RECORDS * MAX_LEN)
    ) u_pay_ram (
        .aclk  (aclk),
        .we    (pay_we),
        .waddr (pay_waddr),
        .wdata (pay_wdata),
        .raddr (pay_raddr),
        .rdata (pay_rdata)
    );

endmodule

`default_nettype wire
